/* rtl/balanced_ternary_tryte_convert_macros.svh */
// Assertion macros for the balanced-ternary tryte converter.
// Used by the top level; expects signals clk and arst_n in the including scope.
`ifndef BALANCED_TERNARY_TRYTE_CONVERT_MACROS_SVH
`define BALANCED_TERNARY_TRYTE_CONVERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BTT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/btt_pkg.sv */
// Shared types, constants and helper functions for the balanced-ternary tryte converter.
// No dependencies; imported by btt_core and balanced_ternary_tryte_convert.
package btt_pkg;

	localparam int TRIT_COUNT = 6;

	localparam int MODE_W    = 2;
	localparam int TRYTE_W   = 16;
	localparam int INT_IN_W  = 16;
	localparam int INT_OUT_W = 11;

	// mode rides in tuser, tryte_in and int_in in tdata
	localparam int IN_DATA_W   = TRYTE_W + INT_IN_W;
	localparam int IN_TUSER_W  = MODE_W;
	localparam int OUT_ITEM_W  = INT_OUT_W + TRYTE_W;
	localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_ITEM_W + 7) / 8) * 8;

	// Largest magnitude a tryte can hold, and the width of value + MAX_MAG
	localparam int MAX_MAG = (3 ** TRIT_COUNT - 1) / 2;
	localparam int OFS_W   = $clog2(2 * MAX_MAG + 1);

	// Trit codes
	localparam logic [1:0] TRIT_ZERO  = 2'b00;
	localparam logic [1:0] TRIT_PLUS  = 2'b01;
	localparam logic [1:0] TRIT_ODD   = 2'b10;
	localparam logic [1:0] TRIT_MINUS = 2'b11;

	typedef enum logic [MODE_W-1:0] {
		MODE_TO_INT   = 2'd0,
		MODE_TO_TRYTE = 2'd1,
		MODE_NEGATE   = 2'd2
	} mode_t;

	typedef struct packed {
		logic signed [INT_IN_W-1:0] int_in;
		logic [TRYTE_W-1:0]         tryte_in;
		logic [MODE_W-1:0]          mode;
	} btt_in_t;

	typedef struct packed {
		logic [TRYTE_W-1:0]          tryte_out;
		logic signed [INT_OUT_W-1:0] int_out;
	} btt_out_t;

	// Bit position of trit i: three trits per byte, two bits each
	function automatic int trit_pos(input int i);
		return 2 * (i % 3) + 8 * (i / 3);
	endfunction

	function automatic int pow3(input int i);
		int p;
		p = 1;
		for (int k = 0; k < i; k++) begin
			p = p * 3;
		end
		return p;
	endfunction

endpackage

/* rtl/btt_core.sv */
// Combinational converter: tryte to integer, integer to tryte, tryte negate.
// Depends on btt_pkg.
module btt_core (
	input  btt_pkg::btt_in_t  item,
	output btt_pkg::btt_out_t result
);
	import btt_pkg::*;

	logic [INT_OUT_W-1:0] sum;
	logic [TRYTE_W-1:0]   conv_w;
	logic [TRYTE_W-1:0]   neg_w;
	logic [OFS_W-1:0]     rem;
	logic [1:0]           tcode;
	logic [1:0]           dcode;
	logic                 in_range;

	// Tryte to integer: weighted sum, wraps to the output width
	always_comb begin
		sum   = '0;
		tcode = TRIT_ZERO;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			if (trit_pos(i) < TRYTE_W) begin
				tcode = item.tryte_in[trit_pos(i) +: 2];
				unique case (tcode)
					TRIT_ZERO:  sum = sum;
					TRIT_PLUS:  sum = sum + INT_OUT_W'(pow3(i));
					TRIT_ODD:   sum = sum + INT_OUT_W'(2 * pow3(i));
					TRIT_MINUS: sum = sum - INT_OUT_W'(pow3(i));
				endcase
			end
		end
	end

	// Integer to tryte: offset by MAX_MAG, take unbalanced digits from the top, shift each by -1
	always_comb begin
		in_range = ($signed(item.int_in) <= MAX_MAG) && ($signed(item.int_in) >= -MAX_MAG);
		rem      = OFS_W'(int'($signed(item.int_in)) + MAX_MAG);
		conv_w   = '0;
		dcode    = TRIT_ZERO;
		for (int i = TRIT_COUNT - 1; i >= 0; i--) begin
			if (rem >= OFS_W'(2 * pow3(i))) begin
				rem   = rem - OFS_W'(2 * pow3(i));
				dcode = TRIT_PLUS;
			end else if (rem >= OFS_W'(pow3(i))) begin
				rem   = rem - OFS_W'(pow3(i));
				dcode = TRIT_ZERO;
			end else begin
				dcode = TRIT_MINUS;
			end
			if (trit_pos(i) < TRYTE_W) begin
				conv_w[trit_pos(i) +: 2] = dcode;
			end
		end
		if (!in_range) begin
			conv_w = '0;
		end
	end

	// Negate: codes with the low bit set swap sign by flipping the high bit
	always_comb begin
		neg_w = item.tryte_in;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			if (trit_pos(i) < TRYTE_W) begin
				if (item.tryte_in[trit_pos(i)]) begin
					neg_w[trit_pos(i) + 1] = ~item.tryte_in[trit_pos(i) + 1];
				end
			end
		end
	end

	always_comb begin
		result = '0;
		unique case (mode_t'(item.mode))
			MODE_TO_INT:   result.int_out   = $signed(sum);
			MODE_TO_TRYTE: result.tryte_out = conv_w;
			MODE_NEGATE:   result.tryte_out = neg_w;
			default:       result = '0;
		endcase
	end

endmodule

/* rtl/balanced_ternary_tryte_convert.sv */
// Balanced-ternary tryte converter top level: input register, converter, result register.
// Depends on btt_pkg, btt_core and balanced_ternary_tryte_convert_macros.svh.
//
//   channel | direction | fields (lowest bit first)
//   s_*     | in        | tuser: mode[1:0]; tdata: tryte_in[15:0], int_in[31:16]
//   m_*     | out       | tdata: int_out[10:0], tryte_out[26:11], zero pad [31:27]
//
// One item per cycle unless m_tready stalls the output; an accepted input is registered in the
// input register, then in the result register, whose valid flag drives m_tvalid.
// The converter between the two registers sets the clock period.
// A stall on m_tready holds the result register; s_tready drops only when both
// registers are full and m_tready is low.
// arst_n clears both valid flags; payload registers are not reset.
module balanced_ternary_tryte_convert (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [btt_pkg::IN_TDATA_W-1:0]  s_tdata,  // tryte_in, int_in
	input  logic [btt_pkg::IN_TUSER_W-1:0]  s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [btt_pkg::OUT_TDATA_W-1:0] m_tdata   // int_out, tryte_out, zero pad
);
	import btt_pkg::*;

	`include "balanced_ternary_tryte_convert_macros.svh"

	logic     valid_s1;
	btt_in_t  item_s1;
	logic     valid_s2;
	btt_out_t result_s2;
	btt_out_t core_res;
	logic     adv_s2;

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= btt_in_t'({s_tdata[IN_DATA_W-1:0], s_tuser});
		end
	end

	btt_core u_core (
		.item   (item_s1),
		.result (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result until the downstream transaction completes
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= core_res;
		end
	end

	assign m_tvalid = valid_s2;

	always_comb begin
		m_tdata                 = '0;
		m_tdata[OUT_ITEM_W-1:0] = result_s2;
	end

	`BTT_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, valid_s1,
		"accepted transaction did not reach the input register")
	`BTT_ASSERT_NEXT(a_s1_moves_on, valid_s1 && !valid_s2, valid_s2,
		"input register did not advance into an empty result register")
	`BTT_ASSERT_NOW(a_ready_when_out_empty, !valid_s2, s_tready,
		"input blocked while result register is empty")
	`BTT_ASSERT_NOW(a_one_field_used, valid_s2,
		(result_s2.int_out == '0) || (result_s2.tryte_out == '0),
		"result carries both an integer and a tryte")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for balanced_ternary_tryte_convert: stream stimulus and an inline
// predictor of all three conversions, with a scoreboard on the result stream.
// Depends on btt_pkg and the RTL of the converter only.
module tb_top;
	import btt_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	// Bit offset of each trit inside the 16-bit tryte word
	localparam int          TRIT_BIT [6] = '{0, 2, 4, 8, 10, 12};
	localparam int          MAG_LIMIT = 364;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_style_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	btt_out_t  pending_results [$];
	int        errors = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	bit        tx_gaps = 1'b0;
	rx_style_t rx_style = RX_ALWAYS;
	int        hold_gen = 0;
	int        hold_seen = 0;
	int        hold_len = 0;
	int        hold_left = 0;
	logic [7:0] rx_pat = 8'b1011_0111;

	balanced_ternary_tryte_convert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // tryte_in, int_in
		.s_tuser  (s_tuser),   // mode
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)    // int_out, tryte_out, zero pad
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic logic [10:0] tryte_value(input logic [15:0] w);
		int sum;
		int weight;
		logic [1:0] code;
		sum = 0;
		weight = 1;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			code = w[TRIT_BIT[i] +: 2];
			if (code == TRIT_MINUS)
				sum = sum - weight;
			else
				sum = sum + int'(code) * weight;
			weight = weight * 3;
		end
		return sum[10:0];
	endfunction

	function automatic logic [15:0] tryte_from_int(input logic signed [15:0] v);
		int mag;
		int r;
		bit neg;
		logic [15:0] w;
		neg = (v < 0);
		mag = neg ? -int'(v) : int'(v);
		w = '0;
		if (mag == 0 || mag > MAG_LIMIT)
			return '0;
		for (int i = 0; i < TRIT_COUNT && mag > 0; i++) begin
			r = mag % 3;
			mag = mag / 3;
			if (r == 2) begin
				mag++;
				w[TRIT_BIT[i] +: 2] = neg ? TRIT_PLUS : TRIT_MINUS;
			end else if (r == 1) begin
				w[TRIT_BIT[i] +: 2] = neg ? TRIT_MINUS : TRIT_PLUS;
			end
		end
		return w;
	endfunction

	function automatic logic [15:0] tryte_negated(input logic [15:0] w);
		logic [15:0] n;
		n = w;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			if (w[TRIT_BIT[i] +: 2] == TRIT_PLUS)
				n[TRIT_BIT[i] +: 2] = TRIT_MINUS;
			else if (w[TRIT_BIT[i] +: 2] == TRIT_MINUS)
				n[TRIT_BIT[i] +: 2] = TRIT_PLUS;
		end
		return n;
	endfunction

	function automatic btt_out_t convert(input logic [1:0] mode, input logic [15:0] tryte,
			input logic signed [15:0] intv);
		btt_out_t r;
		r = '0;
		case (mode)
			MODE_TO_INT:   r.int_out   = tryte_value(tryte);
			MODE_TO_TRYTE: r.tryte_out = tryte_from_int(intv);
			MODE_NEGATE:   r.tryte_out = tryte_negated(tryte);
			default:       r = '0;
		endcase
		return r;
	endfunction

	// ---------------- sender ----------------

	task automatic send_item(input logic [1:0] mode, input logic [15:0] tryte,
			input logic signed [15:0] intv);
		btt_in_t item;
		item.mode = mode;
		item.tryte_in = tryte;
		item.int_in = intv;
		s_tuser <= item.mode;
		s_tdata <= IN_TDATA_W'({item.int_in, item.tryte_in});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(convert(mode, tryte, intv));
	endtask

	task automatic idle(input int n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Break the stream into bursts with random gaps between them
	task automatic pace();
		if (!tx_gaps)
			return;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle(($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6));
		end
		burst_left--;
	endtask

	// Well-formed tryte from codes 00/01/11, optionally with stray bits and the unused code
	function automatic logic [15:0] random_tryte(input bit noisy);
		logic [15:0] w;
		int pick;
		w = '0;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			pick = $urandom_range(0, 2);
			w[TRIT_BIT[i] +: 2] = (pick == 0) ? TRIT_ZERO : (pick == 1) ? TRIT_PLUS : TRIT_MINUS;
			if (noisy && $urandom_range(0, 5) == 0)
				w[TRIT_BIT[i] +: 2] = TRIT_ODD;
		end
		if (noisy)
			w = w | (16'($urandom) & 16'hC0C0);
		return w;
	endfunction

	function automatic logic [15:0] random_int();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			return 16'($urandom_range(0, 2 * MAG_LIMIT) - MAG_LIMIT);
		else if (sel < 15)
			return 16'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(MAG_LIMIT - 4, MAG_LIMIT + 4));
		return 16'($urandom);
	endfunction

	// ---------------- receiver ----------------

	always @(posedge clk) begin
		if (hold_seen != hold_gen) begin
			hold_seen = hold_gen;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					rx_pat = {rx_pat[6:0], rx_pat[7]};
					if ($urandom_range(0, 63) == 0)
						rx_pat = 8'($urandom) | 8'h01;
					m_tready <= rx_pat[0];
				end
			endcase
		end
	end

	// Scoreboard: each result transaction against the oldest expectation
	always @(posedge clk) begin
		btt_out_t got;
		btt_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = btt_out_t'(m_tdata[OUT_ITEM_W-1:0]);
			if (pending_results.size() == 0) begin
				$error("result with no expectation: int_out=%0d tryte_out=%h",
					got.int_out, got.tryte_out);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.int_out !== want.int_out) begin
					$error("int_out: expected %0d, actual %0d", want.int_out, got.int_out);
					errors++;
				end
				if (got.tryte_out !== want.tryte_out) begin
					$error("tryte_out: expected %h, actual %h", want.tryte_out, got.tryte_out);
					errors++;
				end
			end
		end
	end

	// ---------------- tests ----------------

	task automatic test_directed();
		tx_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		send_item(MODE_TO_INT, 16'h0000, 16'sd0);
		send_item(MODE_TO_INT, 16'h1515, 16'sd0);     // all +1
		send_item(MODE_TO_INT, 16'h3F3F, 16'sd0);     // all -1
		send_item(MODE_TO_INT, 16'h2A2A, 16'sd0);     // unused code everywhere
		send_item(MODE_TO_INT, 16'hFFFF, -16'sd1);    // stray bits set too
		send_item(MODE_TO_INT, 16'hC0C0, 16'sd0);     // stray bits only
		send_item(MODE_TO_TRYTE, 16'hFFFF, 16'sd0);
		send_item(MODE_TO_TRYTE, 16'h0000, 16'sd1);
		send_item(MODE_TO_TRYTE, 16'h0000, -16'sd1);
		send_item(MODE_TO_TRYTE, 16'h0000, 16'sd2);
		send_item(MODE_TO_TRYTE, 16'h0000, 16'sd364);
		send_item(MODE_TO_TRYTE, 16'h0000, -16'sd364);
		send_item(MODE_TO_TRYTE, 16'h0000, 16'sd365);
		send_item(MODE_TO_TRYTE, 16'h0000, -16'sd365);
		send_item(MODE_TO_TRYTE, 16'h0000, 16'sh7FFF);
		send_item(MODE_TO_TRYTE, 16'hFFFF, 16'sh8000);
		send_item(MODE_NEGATE, 16'h1515, 16'sd0);
		send_item(MODE_NEGATE, 16'h3F3F, 16'sd0);
		send_item(MODE_NEGATE, 16'h2A2A, 16'sd0);
		send_item(MODE_NEGATE, 16'hFFFF, 16'sd0);
		send_item(MODE_NEGATE, 16'hC0C0, 16'sd0);
		send_item(MODE_UNUSED, 16'hFFFF, -16'sd1);
		send_item(MODE_UNUSED, 16'h1515, 16'sd100);
		idle(3);
	endtask

	task automatic test_to_int_random();
		tx_gaps = 1'b1;
		rx_style = RX_RANDOM;
		repeat (300) begin
			pace();
			send_item(MODE_TO_INT,
				($urandom_range(0, 4) == 0) ? 16'($urandom) : random_tryte($urandom_range(0, 1)),
				16'($urandom));
		end
	endtask

	task automatic test_to_tryte_random();
		tx_gaps = 1'b1;
		rx_style = RX_PATTERN;
		repeat (350) begin
			pace();
			send_item(MODE_TO_TRYTE, 16'($urandom), random_int());
		end
	endtask

	task automatic test_negate_random();
		// back to back, receiver never stalls
		tx_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		repeat (300) begin
			send_item(MODE_NEGATE,
				($urandom_range(0, 4) == 0) ? 16'($urandom) : random_tryte($urandom_range(0, 1)),
				16'($urandom));
		end
	endtask

	task automatic test_mixed_random();
		tx_gaps = 1'b1;
		rx_style = RX_RANDOM;
		repeat (250) begin
			pace();
			send_item(2'($urandom), 16'($urandom),
				$urandom_range(0, 1) ? random_int() : 16'($urandom));
		end
	endtask

	task automatic test_backpressure();
		// long hold-off while the sender keeps offering: pipeline fills, input stalls
		tx_gaps = 1'b0;
		rx_style = RX_ALWAYS;
		hold_len = 300;
		hold_gen++;
		repeat (50) begin
			send_item(2'($urandom_range(0, 2)), random_tryte(1'b0), random_int());
		end
		rx_style = RX_PATTERN;
		repeat (30) begin
			send_item(2'($urandom), 16'($urandom), random_int());
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_to_int_random();
		test_to_tryte_random();
		test_negate_random();
		test_mixed_random();
		test_backpressure();
		idle(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			errors++;
		end
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

endmodule
